### hw/rtl/u8dec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u8dec_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD2_MIN = 8'hC0;
  localparam logic [7:0] MASK4     = 8'h07;
  localparam logic [7:0] MASK3     = 8'h0F;
  localparam logic [7:0] MASK2     = 8'h1F;
  localparam logic [7:0] CONT_MASK = 8'h3F;

  // one classified byte on its way from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       first;  // single byte or lead of a new sequence
    logic       emit;   // this byte completes a code point
    logic [2:0] count;  // bytes in the code point when emit is set
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [2:0] expected_len(input logic [7:0] lead);
    logic [2:0] len;
    if (lead >= LEAD4_MIN) begin
      len = 3'd4;
    end else if (lead >= LEAD3_MIN) begin
      len = 3'd3;
    end else if (lead >= LEAD2_MIN) begin
      len = 3'd2;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  function automatic logic [20:0] assemble(input logic [7:0]  lead,
                                           input logic [17:0] cont,
                                           input logic [2:0]  count);
    logic [20:0] cp;
    unique case (count)
      3'd4:    cp = {(lead[2:0] & MASK4[2:0]), cont};
      3'd3:    cp = {5'd0, (lead[3:0] & MASK3[3:0]), cont[11:0]};
      3'd2:    cp = {10'd0, (lead[4:0] & MASK2[4:0]), cont[5:0]};
      default: cp = {13'd0, lead};
    endcase
    return cp;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/u8dec_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface u8dec_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8dec_cp_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  bytes_used;

  modport source (output valid, output code_point, output bytes_used, input ready);
  modport sink (input valid, input code_point, input bytes_used, output ready);
endinterface

`default_nettype wire

### hw/rtl/utf8_lenient_decoder_top.sv
// A final byte is registered in the queue and then in the output register.
// Throughput: one byte per cycle unless the queue is full, set by the sequence
//   tracker in the front end; a stalled output holds the back end while the queue fills.
// Reset: synchronous, active low; clears the sequence state, queue pointers and
//   output valid. Payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module utf8_lenient_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = u8dec_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  u8dec_byte_if.sink in_ch,
  u8dec_cp_if.source out_ch
);
  import u8dec_pkg::*;

  q_entry_t  push_entry;
  q_entry_t  head;
  q_status_t q_stat;
  logic      push;
  logic      pop;

  u8dec_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  u8dec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  u8dec_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // a byte marked last always closes its code point
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    push && in_ch.last_byte |-> push_entry.emit)
    else $error("last byte did not complete a code point");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  a_single_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.bytes_used == 3'd1 |-> out_ch.code_point[20:8] == '0)
    else $error("single-byte code point out of range");

  a_two_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.bytes_used == 3'd2 |-> out_ch.code_point[20:11] == '0)
    else $error("two-byte code point out of range");

endmodule

`default_nettype wire

### hw/rtl/u8dec_front.sv
`timescale 1ns / 1ps
`default_nettype none

module u8dec_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  u8dec_byte_if.sink                in_ch,
  input  wire u8dec_pkg::q_status_t q_stat,
  output logic                      push,
  output u8dec_pkg::q_entry_t       push_entry
);
  import u8dec_pkg::*;

  logic       open_r, open_nxt;
  logic [2:0] len_r, len_nxt;
  logic [1:0] held_r, held_nxt;
  logic [2:0] byte_len;
  logic [2:0] count;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && in_ch.ready;
  assign byte_len    = expected_len(in_ch.data_byte);
  assign count       = {1'b0, held_r} + 3'd1;

  always_comb begin
    open_nxt         = open_r;
    len_nxt          = len_r;
    held_nxt         = held_r;
    push_entry.data  = in_ch.data_byte;
    push_entry.first = !open_r;
    push_entry.emit  = 1'b0;
    push_entry.count = 3'd1;
    if (!open_r) begin
      if (byte_len == 3'd1 || in_ch.last_byte) begin
        push_entry.emit = 1'b1;
      end else begin
        open_nxt = 1'b1;
        len_nxt  = byte_len;
        held_nxt = 2'd1;
      end
    end else begin
      push_entry.count = count;
      if (count >= len_r || in_ch.last_byte) begin
        push_entry.emit = 1'b1;
        open_nxt        = 1'b0;
        held_nxt        = 2'd0;
      end else begin
        held_nxt = count[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      len_r  <= 3'd1;
      held_r <= 2'd0;
    end else if (push) begin
      open_r <= open_nxt;
      len_r  <= len_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/u8dec_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module u8dec_queue #(
  parameter int unsigned DEPTH = u8dec_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire u8dec_pkg::q_entry_t push_entry,
  input  wire logic                pop,
  output u8dec_pkg::q_entry_t      head,
  output u8dec_pkg::q_status_t     stat
);
  import u8dec_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/u8dec_back.sv
`timescale 1ns / 1ps
`default_nettype none

module u8dec_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire u8dec_pkg::q_entry_t  head,
  input  wire u8dec_pkg::q_status_t q_stat,
  output logic                      pop,
  u8dec_cp_if.source                out_ch
);
  import u8dec_pkg::*;

  logic [7:0]  lead_r;
  logic [17:0] cont_r;
  logic [17:0] cont_nxt;
  logic        out_valid_r;
  logic [20:0] code_point_r;
  logic [2:0]  bytes_used_r;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.code_point = code_point_r;
  assign out_ch.bytes_used = bytes_used_r;

  // entries that complete nothing never wait on the output register
  assign pop      = !q_stat.empty && (!head.emit || !out_valid_r || out_ch.ready);
  assign cont_nxt = {cont_r[11:0], head.data[5:0] & CONT_MASK[5:0]};

  always_ff @(posedge clk) begin
    if (pop) begin
      if (head.first) begin
        lead_r <= head.data;
        cont_r <= '0;
      end else begin
        cont_r <= cont_nxt;
      end
      if (head.emit) begin
        code_point_r <= head.first ? {13'd0, head.data}
                                   : assemble(lead_r, cont_nxt, head.count);
        bytes_used_r <= head.count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && head.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire
